// ===== design/msha_pkg.sv =====
// ----------------------------------------------------------------------------
// msha_pkg
// Shared constants, datapath command codes and the controller-to-datapath
// command struct for the multilinear seed hash block.
// ----------------------------------------------------------------------------
package msha_pkg;

  localparam int MSHA_MAX_DIGESTS = 8;

  localparam logic [63:0] START_COEF = 64'hc9f7_36a1_a00d_1f5f;
  localparam logic [63:0] STEP_COEF  = 64'h8822_6cde_0de8_26bf;
  localparam logic [63:0] MIX1       = 64'h62a9_d9ed_7997_05f5;
  localparam logic [63:0] MIX2       = 64'hcb24_d0a5_c88c_35b3;
  localparam int          MIX_SH1    = 33;
  localparam int          MIX_SH2    = 28;

  localparam logic [2:0]  SEED_BLOCKS_RST = 3'd4;

  // Datapath micro-ops
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP        = 4'd0;   // hold
  localparam dp_op_t OP_CAPTURE    = 4'd1;   // latch input word
  localparam dp_op_t OP_INIT_START = 4'd2;   // coef = start
  localparam dp_op_t OP_INIT_STEP  = 4'd3;   // coef += step, digest[idx] = coef
  localparam dp_op_t OP_RD         = 4'd4;   // read digest[idx], coef += step
  localparam dp_op_t OP_A0         = 4'd5;   // acc = digest + coef.lo * w
  localparam dp_op_t OP_A1         = 4'd6;   // digest[idx] = acc + coef.hi * w << 32
  localparam dp_op_t OP_LD         = 4'd7;   // x = digest + coef, x ^= x >> 33
  localparam dp_op_t OP_M0         = 4'd8;   // first mix multiply, three partials
  localparam dp_op_t OP_M1         = 4'd9;
  localparam dp_op_t OP_M2         = 4'd10;  // ends with x ^= x >> 28
  localparam dp_op_t OP_N0         = 4'd11;  // second mix multiply
  localparam dp_op_t OP_N1         = 4'd12;
  localparam dp_op_t OP_N2         = 4'd13;  // upper half to output register

  typedef struct packed {
    dp_op_t op;
    logic   last;   // item being finished is the last of the run
  } dp_cmd_t;

endpackage

// ===== design/msha_dp.sv =====
// ----------------------------------------------------------------------------
// msha_dp
// Datapath: digest memory, coefficient, one shared 32x32 multiplier with a
// 64-bit accumulator, and the output register.
// ----------------------------------------------------------------------------
module msha_dp
  import msha_pkg::*;
#(
  parameter int MAX_DIGESTS = MSHA_MAX_DIGESTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dp_cmd_t                        cmd,
  input  logic [$clog2(MAX_DIGESTS)-1:0] idx,
  input  logic [31:0]                    in_word,
  output logic                           out_free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_seed_value,
  output logic [2:0]                     out_value_index,
  output logic                           out_last_value
);

  logic [63:0] digest_mem_r [MAX_DIGESTS];
  logic [63:0] rd_r;
  logic [31:0] w_r,    w_nxt;
  logic [63:0] coef_r, coef_nxt;
  logic [63:0] acc_r,  acc_nxt;
  logic [63:0] op_r,   op_nxt;
  logic        out_valid_r;
  logic [31:0] out_seed_r;
  logic [2:0]  out_index_r;
  logic        out_last_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, prod_sh, sum, coef_step, premix;
  logic        mem_we;
  logic [63:0] mem_wdata;
  logic        load_out;

  assign prod      = 64'(mul_a) * 64'(mul_b);
  assign prod_sh   = {prod[31:0], 32'd0};
  assign sum       = acc_r + prod_sh;
  assign coef_step = coef_r + STEP_COEF;
  assign premix    = rd_r + coef_r;
  assign out_free  = !out_valid_r || out_ready;

  // multiplier operand select
  always_comb begin
    mul_a = coef_r[31:0];
    mul_b = w_r;
    unique case (cmd.op) inside
      OP_A1:        mul_a = coef_r[63:32];
      OP_M0:        begin mul_a = op_r[31:0];  mul_b = MIX1[31:0];  end
      OP_M1:        begin mul_a = op_r[31:0];  mul_b = MIX1[63:32]; end
      OP_M2:        begin mul_a = op_r[63:32]; mul_b = MIX1[31:0];  end
      OP_N0:        begin mul_a = op_r[31:0];  mul_b = MIX2[31:0];  end
      OP_N1:        begin mul_a = op_r[31:0];  mul_b = MIX2[63:32]; end
      OP_N2:        begin mul_a = op_r[63:32]; mul_b = MIX2[31:0];  end
      default:      ;
    endcase
  end

  // register updates per micro-op
  always_comb begin
    w_nxt     = w_r;
    coef_nxt  = coef_r;
    acc_nxt   = acc_r;
    op_nxt    = op_r;
    mem_we    = 1'b0;
    mem_wdata = coef_step;
    load_out  = 1'b0;
    unique case (cmd.op) inside
      OP_CAPTURE:     w_nxt = in_word;
      OP_INIT_START:  coef_nxt = START_COEF;
      OP_INIT_STEP: begin
        coef_nxt  = coef_step;
        mem_we    = 1'b1;
        mem_wdata = coef_step;
      end
      OP_RD:          coef_nxt = coef_step;
      OP_A0:          acc_nxt = rd_r + prod;
      OP_A1: begin
        mem_we    = 1'b1;
        mem_wdata = sum;
      end
      OP_LD:          op_nxt = premix ^ (premix >> MIX_SH1);
      OP_M0, OP_N0:   acc_nxt = prod;
      OP_M1, OP_N1:   acc_nxt = sum;
      OP_M2:          op_nxt = sum ^ (sum >> MIX_SH2);
      OP_N2:          load_out = out_free;
      default:        ;
    endcase
  end

  // digest memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digest_mem_r[idx] <= mem_wdata;
    end
    rd_r <= digest_mem_r[idx];
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    coef_r <= coef_nxt;
    acc_r  <= acc_nxt;
    op_r   <= op_nxt;
    if (load_out) begin
      out_seed_r  <= sum[63:32];
      out_index_r <= 3'(idx);
      out_last_r  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seed_value  = out_seed_r;
  assign out_value_index = out_index_r;
  assign out_last_value  = out_last_r;

endmodule

// ===== design/msha_ctrl.sv =====
// ----------------------------------------------------------------------------
// msha_ctrl
// Sequencer: init sweep, per-digest absorb steps and per-digest finalize
// steps; holds the seed block count and the digest index.
// ----------------------------------------------------------------------------
module msha_ctrl
  import msha_pkg::*;
#(
  parameter int MAX_DIGESTS = MSHA_MAX_DIGESTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_seed_blocks,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_final_word,
  input  logic                           out_free,
  output dp_cmd_t                        cmd,
  output logic [$clog2(MAX_DIGESTS)-1:0] idx
);

  localparam int IW   = $clog2(MAX_DIGESTS);
  localparam int HALF = MAX_DIGESTS / 2;

  localparam logic [3:0] S_INIT0 = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_IDLE  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_A0    = 4'd4;
  localparam logic [3:0] S_A1    = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_LD  = 4'd7;
  localparam logic [3:0] S_M0    = 4'd8;
  localparam logic [3:0] S_M1    = 4'd9;
  localparam logic [3:0] S_M2    = 4'd10;
  localparam logic [3:0] S_N0    = 4'd11;
  localparam logic [3:0] S_N1    = 4'd12;
  localparam logic [3:0] S_N2    = 4'd13;

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [2:0]    seed_blocks_r, seed_blocks_nxt;
  logic          fin_r, fin_nxt;
  logic [31:0]   blocks;
  logic [IW-1:0] last_idx;
  logic          at_last;

  // digests in use = 2 * clamp(seed_blocks, 1, MAX_DIGESTS/2)
  always_comb begin
    blocks = {29'd0, seed_blocks_r};
    if (blocks == 32'd0) begin
      blocks = 32'd1;
    end
    if (blocks > 32'(HALF)) begin
      blocks = 32'(HALF);
    end
    last_idx = IW'((blocks << 1) - 32'd1);
  end

  assign at_last = (idx_r == last_idx);

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    seed_blocks_nxt = seed_blocks_r;
    fin_nxt         = fin_r;
    cmd.op          = OP_NOP;
    cmd.last        = at_last;
    cfg_ready       = 1'b0;
    in_ready        = 1'b0;
    unique case (state_r)
      S_INIT0: begin
        cmd.op    = OP_INIT_START;
        idx_nxt   = '0;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.op = OP_INIT_STEP;
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        idx_nxt   = '0;
        if (cfg_valid) begin
          seed_blocks_nxt = cfg_seed_blocks;
          state_nxt       = S_INIT0;
        end else if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          fin_nxt   = in_final_word;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_A0;
      end
      S_A0: begin
        cmd.op    = OP_A0;
        state_nxt = S_A1;
      end
      S_A1: begin
        cmd.op = OP_A1;
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = fin_r ? S_F_RD : S_IDLE;
        end else begin
          idx_nxt   = IW'(idx_r + 1'b1);
          state_nxt = S_RD;
        end
      end
      S_F_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_F_LD;
      end
      S_F_LD: begin
        cmd.op    = OP_LD;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.op    = OP_M0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_N0;
      end
      S_N0: begin
        cmd.op    = OP_N0;
        state_nxt = S_N1;
      end
      S_N1: begin
        cmd.op    = OP_N1;
        state_nxt = S_N2;
      end
      S_N2: begin
        cmd.op = OP_N2;
        if (out_free) begin
          if (at_last) begin
            state_nxt = S_INIT0;
          end else begin
            idx_nxt   = IW'(idx_r + 1'b1);
            state_nxt = S_F_RD;
          end
        end
      end
      default: begin
        state_nxt = S_INIT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT0;
      idx_r         <= '0;
      seed_blocks_r <= SEED_BLOCKS_RST;
      fin_r         <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      seed_blocks_r <= seed_blocks_nxt;
      fin_r         <= fin_nxt;
    end
  end

  assign idx = idx_r;

endmodule

// ===== design/multilinear_seed_hash_absorb.sv =====
// ----------------------------------------------------------------------------
// multilinear_seed_hash_absorb
// Multilinear hash over 32-bit words into 2..MAX_DIGESTS 64-bit digests,
// with a 64-bit mixer turning each digest into one 32-bit seed value.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel  : cfg_seed_blocks sets the block count (digests D = 2x,
//                  clamped to 1..MAX_DIGESTS/2 blocks). Taken only when the
//                  block is idle; every write restarts the hash.
//   in channel   : one word per item; in_final_word closes the run.
//   out channel  : D items per final word, index 0..D-1, out_last_value on
//                  the last one. Nothing comes out for other words.
// Sequence (D digests, one shared 32x32 multiplier sets the pace):
//   ordinary word : capture, then per digest
//                   (read, low product, high product + write back)
//   final word    : as an ordinary word, then per digest the mix (read,
//                   add and shift, then two 64-bit multiplies of three
//                   partial products each), then the re-init sweep
// Reset and every config write run a sweep that reloads the digest memory
// and coefficient; in_ready stays low during it.
// A stalled receiver only holds the finishing step of the next result;
// the output register keeps its item until out_ready.
// ----------------------------------------------------------------------------
module multilinear_seed_hash_absorb
  import msha_pkg::*;
#(
  parameter int MAX_DIGESTS = MSHA_MAX_DIGESTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_seed_blocks,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  input  logic        in_final_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_seed_value,
  output logic [2:0]  out_value_index,
  output logic        out_last_value
);

  dp_cmd_t                        cmd;
  logic [$clog2(MAX_DIGESTS)-1:0] idx;
  logic                           out_free;

  // sequencer: which micro-op, which digest
  msha_ctrl #(
    .MAX_DIGESTS (MAX_DIGESTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_seed_blocks (cfg_seed_blocks),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_final_word   (in_final_word),
    .out_free        (out_free),
    .cmd             (cmd),
    .idx             (idx)
  );

  // storage, multiplier and output register
  msha_dp #(
    .MAX_DIGESTS (MAX_DIGESTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .idx             (idx),
    .in_word         (in_word),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seed_value  (out_seed_value),
    .out_value_index (out_value_index),
    .out_last_value  (out_last_value)
  );

endmodule

// ===== design/msha_checker.sv =====
// ----------------------------------------------------------------------------
// msha_checker
// Port-level checks for the multilinear seed hash block, bound to the top.
// ----------------------------------------------------------------------------
module msha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_seed_value,
  input logic [2:0]  out_value_index,
  input logic        out_last_value
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seed_value)
      && $stable(out_value_index) && $stable(out_last_value))
    else $error("result changed while stalled");

  // config and word never taken together
  a_no_dual: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_ready && in_valid && in_ready))
    else $error("config write and word taken in one cycle");

  // a taken word keeps the block busy
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("ready right after taking a word");

  // config write starts the reload sweep
  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready && !cfg_ready)
    else $error("ready right after a config write");

  // out of reset: reloading, nothing pending
  a_rst_state: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready && !out_valid)
    else $error("not in reload after reset");

endmodule

bind multilinear_seed_hash_absorb msha_checker u_msha_checker (.*);
